@@ design/can_sx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN signal extract and scale: shared definitions
// Field widths, register indexes and the frame and result transaction types.
// ----------------------------------------------------------------------------
package can_sx_pkg;

	localparam int ID_W       = 29;
	localparam int LEN_W      = 4;
	localparam int START_W    = 6;
	localparam int BITLEN_W   = 7;
	localparam int FACTOR_W   = 32;
	localparam int OFFSET_W   = 48;
	localparam int PAYLOAD_W  = 64;
	localparam int VALUE_W    = 64;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;

	// Byte count of the payload field.
	localparam int PAYLOAD_BYTES = PAYLOAD_W / 8;

	// Width of the exact intermediate arithmetic: a 65-bit raw value times a
	// 32-bit factor, plus offset and bound terms, with headroom.
	localparam int WIDE_W = 100;

	// One in Q16 fixed point.
	localparam int Q_ONE = 65536;

	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_BIT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_LENGTH      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MOTOROLA_ORDER  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UNSIGNED_SIGNAL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_OFFSET    = 3'd7;

	typedef struct packed {
		logic [ID_W-1:0]      frame_id;
		logic [LEN_W-1:0]     frame_length;
		logic [PAYLOAD_W-1:0] payload;
	} frame_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] scaled_value;
		logic                      status;
		logic                      clamped;
	} result_t;

endpackage

@@ design/can_signal_extract_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN signal extract and scale
// Decodes one configured signal from each CAN frame and scales it to Q48.16.
// ----------------------------------------------------------------------------
// The block takes one frame transaction in every clock cycle when the output is
// not stalled, and returns one result transaction for each, in order. Each frame
// passes through an eight-register pipeline whose first register is loaded at
// acceptance: input register, bit gather, two 33 by 32 bit partial products,
// sum with the offset, lower bound, the two clamps, and the output register.
// Every stage holds its transaction on its own, so empty stages keep taking
// frames while a finished result waits.
// Configuration is to be written only while no transaction is in flight.
module can_signal_extract_scale (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                frame_valid,
	output logic                                frame_ready,
	input  can_sx_pkg::frame_t                  frame,
	output logic                                result_valid,
	input  logic                                result_ready,
	output can_sx_pkg::result_t                 result,
	input  logic                                cfg_write,
	input  logic [can_sx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [can_sx_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int W = can_sx_pkg::WIDE_W;
	localparam int PW = can_sx_pkg::PAYLOAD_W;
	localparam logic signed [W-1:0] ONE_W = W'(can_sx_pkg::Q_ONE);
	localparam logic signed [can_sx_pkg::VALUE_W-1:0] VAL_MAX =
		{1'b0, {(can_sx_pkg::VALUE_W-1){1'b1}}};
	localparam logic signed [can_sx_pkg::VALUE_W-1:0] VAL_MIN =
		{1'b1, {(can_sx_pkg::VALUE_W-1){1'b0}}};

	// Configuration registers.
	logic [can_sx_pkg::ID_W-1:0]            expected_id_q;
	logic [can_sx_pkg::LEN_W-1:0]           expected_length_q;
	logic [can_sx_pkg::START_W-1:0]         start_bit_q;
	logic [can_sx_pkg::BITLEN_W-1:0]        bit_length_q;
	logic                                   motorola_order_q;
	logic                                   unsigned_signal_q;
	logic signed [can_sx_pkg::FACTOR_W-1:0] scale_factor_q;
	logic signed [can_sx_pkg::OFFSET_W-1:0] scale_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q     <= '0;
			expected_length_q <= 4'd8;
			start_bit_q       <= '0;
			bit_length_q      <= 7'd8;
			motorola_order_q  <= 1'b0;
			unsigned_signal_q <= 1'b1;
			scale_factor_q    <= 32'sd65536;
			scale_offset_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				can_sx_pkg::REG_EXPECTED_ID:
					expected_id_q <= cfg_data[can_sx_pkg::ID_W-1:0];
				can_sx_pkg::REG_EXPECTED_LENGTH:
					expected_length_q <= cfg_data[can_sx_pkg::LEN_W-1:0];
				can_sx_pkg::REG_START_BIT:
					start_bit_q <= cfg_data[can_sx_pkg::START_W-1:0];
				can_sx_pkg::REG_BIT_LENGTH:
					bit_length_q <= cfg_data[can_sx_pkg::BITLEN_W-1:0];
				can_sx_pkg::REG_MOTOROLA_ORDER:
					motorola_order_q <= cfg_data[0];
				can_sx_pkg::REG_UNSIGNED_SIGNAL:
					unsigned_signal_q <= cfg_data[0];
				can_sx_pkg::REG_SCALE_FACTOR:
					scale_factor_q <= cfg_data[can_sx_pkg::FACTOR_W-1:0];
				can_sx_pkg::REG_SCALE_OFFSET:
					scale_offset_q <= cfg_data[can_sx_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// Derived configuration. The user must keep it stable while transactions are in flight; the block does not enforce it.
	logic                          sgn;
	logic [can_sx_pkg::BITLEN_W-1:0] len_eff;
	logic [can_sx_pkg::BITLEN_W-1:0] len_m1;
	logic signed [W-1:0]           off_w;

	always_comb begin
		sgn = ~unsigned_signal_q;
		if (bit_length_q == '0)
			len_eff = 7'd1;
		else if (bit_length_q > 7'd64)
			len_eff = 7'd64;
		else
			len_eff = bit_length_q;
		len_m1 = len_eff - 7'd1;
		off_w  = W'(scale_offset_q);
	end

	// Valid bits and per-stage load enables. A stage loads when it is empty
	// or when its contents move on in the same cycle.
	logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, vo_q;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ldo;

	assign ldo = ~vo_q | result_ready;
	assign ld7 = ~v7_q | ldo;
	assign ld6 = ~v6_q | ld7;
	assign ld5 = ~v5_q | ld6;
	assign ld4 = ~v4_q | ld5;
	assign ld3 = ~v3_q | ld4;
	assign ld2 = ~v2_q | ld3;
	assign ld1 = ~v1_q | ld2;

	assign frame_ready  = ld1;
	assign result_valid = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			v6_q <= 1'b0;
			v7_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (ld1) v1_q <= frame_valid;
			if (ld2) v2_q <= v1_q;
			if (ld3) v3_q <= v2_q;
			if (ld4) v4_q <= v3_q;
			if (ld5) v5_q <= v4_q;
			if (ld6) v6_q <= v5_q;
			if (ld7) v7_q <= v6_q;
			if (ldo) vo_q <= v7_q;
		end
	end

	// Stage 1: input register.
	can_sx_pkg::frame_t frame_s1;

	always_ff @(posedge clk) begin
		if (ld1) frame_s1 <= frame;
	end

	// Stage 2: identity check and bit gather. Motorola order walks bytes
	// downwards, which is an upward walk in the byte-reversed payload.
	logic [PW-1:0]          rev_payload;
	logic [PW-1:0]          gather_src;
	logic [can_sx_pkg::START_W-1:0] gather_amt;
	logic [PW-1:0]          gather_shifted;
	logic [PW-1:0]          len_mask;
	logic [PW-1:0]          raw_u;
	logic                   raw_neg;
	logic signed [PW:0]     raw_c;
	logic                   mismatch_c;

	always_comb begin
		for (int j = 0; j < can_sx_pkg::PAYLOAD_BYTES; j++)
			rev_payload[8*j +: 8] =
				frame_s1.payload[8*(can_sx_pkg::PAYLOAD_BYTES-1-j) +: 8];
		if (motorola_order_q) begin
			gather_src = rev_payload;
			gather_amt = {~start_bit_q[5:3], start_bit_q[2:0]};
		end else begin
			gather_src = frame_s1.payload;
			gather_amt = start_bit_q;
		end
		gather_shifted = gather_src >> gather_amt;
		len_mask = ~({PW{1'b1}} << len_eff);
		raw_u = gather_shifted & len_mask;
		raw_neg = sgn & raw_u[len_m1[5:0]];
		if (raw_neg)
			raw_c = {1'b1, raw_u | ~len_mask};
		else
			raw_c = {1'b0, raw_u};
		mismatch_c = (frame_s1.frame_id != expected_id_q) ||
			(frame_s1.frame_length != expected_length_q);
	end

	logic signed [PW:0] raw_s2;
	logic               mm_s2;

	always_ff @(posedge clk) begin
		if (ld2) begin
			raw_s2 <= raw_c;
			mm_s2  <= mismatch_c;
		end
	end

	// Stage 3: two partial products and the shifted factor for the bound.
	logic signed [32:0]     a_lo;
	logic signed [32:0]     a_hi;
	logic signed [64:0]     pp_lo_c;
	logic signed [64:0]     pp_hi_c;
	logic [can_sx_pkg::BITLEN_W-1:0] bound_sh;
	logic signed [W-1:0]    fsh_c;

	always_comb begin
		a_lo = {1'b0, raw_s2[31:0]};
		a_hi = raw_s2[64:32];
		pp_lo_c = a_lo * scale_factor_q;
		pp_hi_c = a_hi * scale_factor_q;
		bound_sh = sgn ? len_m1 : len_eff;
		fsh_c = W'(scale_factor_q) <<< bound_sh;
	end

	logic signed [64:0]  pp_lo_s3;
	logic signed [64:0]  pp_hi_s3;
	logic signed [W-1:0] fsh_s3;
	logic                mm_s3;

	always_ff @(posedge clk) begin
		if (ld3) begin
			pp_lo_s3 <= pp_lo_c;
			pp_hi_s3 <= pp_hi_c;
			fsh_s3   <= fsh_c;
			mm_s3    <= mm_s2;
		end
	end

	// Stage 4: exact product plus offset, and the upper bound.
	logic signed [W-1:0] res_s4;
	logic signed [W-1:0] vmax_s4;
	logic                mm_s4;

	always_ff @(posedge clk) begin
		if (ld4) begin
			res_s4  <= (W'(pp_hi_s3) <<< 32) + W'(pp_lo_s3) + off_w;
			vmax_s4 <= fsh_s3 + off_w;
			mm_s4   <= mm_s3;
		end
	end

	// Stage 5: lower bound.
	logic signed [W-1:0] res_s5;
	logic signed [W-1:0] vmax_s5;
	logic signed [W-1:0] vmin_s5;
	logic                mm_s5;

	always_ff @(posedge clk) begin
		if (ld5) begin
			res_s5  <= res_s4;
			vmax_s5 <= vmax_s4;
			vmin_s5 <= sgn ? (-vmax_s4 - ONE_W) : off_w;
			mm_s5   <= mm_s4;
		end
	end

	// Stage 6: raise to the lower bound.
	logic signed [W-1:0] res_s6;
	logic signed [W-1:0] vmax_s6;
	logic                clamp_s6;
	logic                mm_s6;

	always_ff @(posedge clk) begin
		if (ld6) begin
			if (res_s5 < vmin_s5) begin
				res_s6   <= vmin_s5;
				clamp_s6 <= 1'b1;
			end else begin
				res_s6   <= res_s5;
				clamp_s6 <= 1'b0;
			end
			vmax_s6 <= vmax_s5;
			mm_s6   <= mm_s5;
		end
	end

	// Stage 7: lower to the upper bound.
	logic signed [W-1:0] res_s7;
	logic                clamp_s7;
	logic                mm_s7;

	always_ff @(posedge clk) begin
		if (ld7) begin
			if (vmax_s6 < res_s6) begin
				res_s7   <= vmax_s6;
				clamp_s7 <= 1'b1;
			end else begin
				res_s7   <= res_s6;
				clamp_s7 <= clamp_s6;
			end
			mm_s7 <= mm_s6;
		end
	end

	// Output register: saturation to the 64-bit range, and the mismatch case.
	logic                fits;
	can_sx_pkg::result_t result_c;

	always_comb begin
		fits = (&res_s7[W-1:can_sx_pkg::VALUE_W-1]) |
			~(|res_s7[W-1:can_sx_pkg::VALUE_W-1]);
		if (mm_s7) begin
			result_c.scaled_value = '0;
			result_c.status       = 1'b1;
			result_c.clamped      = 1'b0;
		end else begin
			if (fits)
				result_c.scaled_value = res_s7[can_sx_pkg::VALUE_W-1:0];
			else
				result_c.scaled_value = res_s7[W-1] ? VAL_MIN : VAL_MAX;
			result_c.status  = 1'b0;
			result_c.clamped = clamp_s7 | ~fits;
		end
	end

	can_sx_pkg::result_t result_q;

	always_ff @(posedge clk) begin
		if (ldo) result_q <= result_c;
	end

	assign result = result_q;

endmodule

@@ dv/can_signal_extract_scale_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN signal extract and scale: testbench
// Drives frame transactions through the decoder under a series of signal
// configurations and idling patterns. A scoreboard predicts each decoded,
// scaled and clamped value and checks every result transaction in order.
// ----------------------------------------------------------------------------
module can_signal_extract_scale_tb;

	typedef struct {
		logic [can_sx_pkg::ID_W-1:0]       expected_id;
		logic [can_sx_pkg::LEN_W-1:0]      expected_length;
		logic [can_sx_pkg::START_W-1:0]    start_bit;
		logic [can_sx_pkg::BITLEN_W-1:0]   bit_length;
		logic                              motorola_order;
		logic                              unsigned_signal;
		logic [can_sx_pkg::FACTOR_W-1:0]   scale_factor;
		logic [can_sx_pkg::OFFSET_W-1:0]   scale_offset;
	} sig_cfg_t;

	class signal_scoreboard;
		sig_cfg_t            cfg;
		can_sx_pkg::result_t pending_results[$];
		int                  mismatches;

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t ERROR %s", $time, msg);
		endfunction

		function can_sx_pkg::result_t decode_frame(can_sx_pkg::frame_t f);
			can_sx_pkg::result_t r;
			logic [63:0] raw;
			logic signed [127:0] value, fw, offs, vmax, vmin, q_one, lim_hi, lim_lo;
			logic signed [can_sx_pkg::FACTOR_W-1:0] fac;
			logic signed [can_sx_pkg::OFFSET_W-1:0] offw;
			int len, byte_idx, bit_pos;
			logic sgn, hit_bound;

			r = '0;
			if (f.frame_id != cfg.expected_id ||
					f.frame_length != cfg.expected_length) begin
				r.status = 1'b1;
				return r;
			end
			len = cfg.bit_length;
			if (len == 0)
				len = 1;
			if (len > 64)
				len = 64;

			// Bits are gathered upward; a byte wrap steps forward or back.
			byte_idx = cfg.start_bit / 8;
			bit_pos = cfg.start_bit % 8;
			raw = '0;
			for (int i = 0; i < len; i++) begin
				if (byte_idx >= 0 && byte_idx < can_sx_pkg::PAYLOAD_BYTES)
					raw[i] = f.payload[byte_idx*8 + bit_pos];
				bit_pos++;
				if (bit_pos == 8) begin
					bit_pos = 0;
					byte_idx += cfg.motorola_order ? -1 : 1;
				end
			end

			sgn = !cfg.unsigned_signal;
			value = {64'd0, raw};
			if (sgn && raw[len-1])
				for (int k = len; k < 128; k++)
					value[k] = 1'b1;

			fac = cfg.scale_factor;
			fw = fac;
			offw = cfg.scale_offset;
			offs = offw;
			value = value * fw + offs;

			q_one = can_sx_pkg::Q_ONE;
			if (sgn) begin
				vmax = (fw <<< (len - 1)) + offs;
				vmin = -vmax - q_one;
			end else begin
				vmax = (fw <<< len) + offs;
				vmin = offs;
			end

			// Lower bound first, then upper, so a negative factor ends on the maximum.
			hit_bound = 1'b0;
			if (value < vmin) begin
				value = vmin;
				hit_bound = 1'b1;
			end
			if (value > vmax) begin
				value = vmax;
				hit_bound = 1'b1;
			end
			lim_hi = 64'sh7FFF_FFFF_FFFF_FFFF;
			lim_lo = 64'sh8000_0000_0000_0000;
			if (value < lim_lo) begin
				value = lim_lo;
				hit_bound = 1'b1;
			end
			if (value > lim_hi) begin
				value = lim_hi;
				hit_bound = 1'b1;
			end

			r.scaled_value = value[63:0];
			r.clamped = hit_bound;
			return r;
		endfunction

		function void note_frame(can_sx_pkg::frame_t f);
			pending_results.push_back(decode_frame(f));
		endfunction

		function void check_result(can_sx_pkg::result_t got);
			can_sx_pkg::result_t exp;

			if (pending_results.size() == 0) begin
				flag($sformatf("result with no frame pending: value %0d status %0b clamped %0b",
					got.scaled_value, got.status, got.clamped));
				return;
			end
			exp = pending_results.pop_front();
			if (got.scaled_value !== exp.scaled_value)
				flag($sformatf("scaled_value expected %0d got %0d",
					exp.scaled_value, got.scaled_value));
			if (got.status !== exp.status)
				flag($sformatf("status expected %0b got %0b", exp.status, got.status));
			if (got.clamped !== exp.clamped)
				flag($sformatf("clamped expected %0b got %0b", exp.clamped, got.clamped));
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              frame_valid;
	logic                              frame_ready;
	can_sx_pkg::frame_t                frame;
	logic                              result_valid;
	logic                              result_ready;
	can_sx_pkg::result_t               result;
	logic                              cfg_write;
	logic [can_sx_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [can_sx_pkg::CFG_DATA_W-1:0] cfg_data;

	signal_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;

	can_signal_extract_scale u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Result side: check every accepted transaction, then decide the next stall.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(input logic [can_sx_pkg::CFG_IDX_W-1:0] idx,
			input logic [can_sx_pkg::CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic apply_config(input sig_cfg_t c);
		write_reg(can_sx_pkg::REG_EXPECTED_ID, 48'(c.expected_id));
		write_reg(can_sx_pkg::REG_EXPECTED_LENGTH, 48'(c.expected_length));
		write_reg(can_sx_pkg::REG_START_BIT, 48'(c.start_bit));
		write_reg(can_sx_pkg::REG_BIT_LENGTH, 48'(c.bit_length));
		write_reg(can_sx_pkg::REG_MOTOROLA_ORDER, 48'(c.motorola_order));
		write_reg(can_sx_pkg::REG_UNSIGNED_SIGNAL, 48'(c.unsigned_signal));
		write_reg(can_sx_pkg::REG_SCALE_FACTOR, 48'(c.scale_factor));
		write_reg(can_sx_pkg::REG_SCALE_OFFSET, c.scale_offset);
		cfg_write <= 1'b0;
		sb.cfg = c;
	endtask

	task automatic send_frame(input can_sx_pkg::frame_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			frame_valid <= 1'b0;
			@(posedge clk);
		end
		frame_valid <= 1'b1;
		frame <= f;
		@(posedge clk);
		while (!frame_ready)
			@(posedge clk);
		sb.note_frame(f);
	endtask

	// Stop sending and wait until every pending result has been returned.
	task automatic drain();
		frame_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic can_sx_pkg::frame_t mk_frame(logic [can_sx_pkg::ID_W-1:0] id,
			logic [can_sx_pkg::LEN_W-1:0] len, logic [can_sx_pkg::PAYLOAD_W-1:0] data);
		can_sx_pkg::frame_t f;

		f.frame_id = id;
		f.frame_length = len;
		f.payload = data;
		return f;
	endfunction

	function automatic sig_cfg_t random_config();
		sig_cfg_t c;

		c.expected_id = 29'($urandom);
		c.expected_length = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
			4'($urandom_range(8));
		c.start_bit = 6'($urandom_range(63));
		case ($urandom_range(5))
			0: c.bit_length = 7'($urandom_range(127));
			1: c.bit_length = 7'd64;
			default: c.bit_length = 7'($urandom_range(64, 1));
		endcase
		c.motorola_order = 1'($urandom_range(1));
		c.unsigned_signal = 1'($urandom_range(1));
		case ($urandom_range(5))
			0: c.scale_factor = 32'h8000_0000;
			1: c.scale_factor = 32'h7FFF_FFFF;
			2: c.scale_factor = $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
			3: c.scale_factor = $urandom_range(262143);
			default: c.scale_factor = $urandom;
		endcase
		case ($urandom_range(4))
			0: c.scale_offset = $urandom_range(1) ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
			1: c.scale_offset = '0;
			default: c.scale_offset = 48'({$urandom, $urandom});
		endcase
		return c;
	endfunction

	// Most frames carry the configured id and byte count; the rest are noise.
	function automatic can_sx_pkg::frame_t random_frame();
		can_sx_pkg::frame_t f;

		f.frame_id = sb.cfg.expected_id;
		f.frame_length = sb.cfg.expected_length;
		if ($urandom_range(9) == 0) begin
			if ($urandom_range(1))
				f.frame_id = 29'($urandom);
			else
				f.frame_length = 4'($urandom_range(15));
		end
		case ($urandom_range(9))
			0: f.payload = '1;
			1: f.payload = '0;
			default: f.payload = {$urandom, $urandom};
		endcase
		return f;
	endfunction

	task automatic directed_part();
		sig_cfg_t c;

		// Reset values.
		c = '{29'd0, 4'd8, 6'd0, 7'd8, 1'b0, 1'b1, 32'h0001_0000, 48'd0};
		apply_config(c);
		send_frame(mk_frame(29'd0, 4'd8, '1));
		send_frame(mk_frame(29'd0, 4'd8, '0));
		send_frame(mk_frame(29'd1, 4'd8, '1));
		send_frame(mk_frame(29'd0, 4'd7, '1));
		send_frame(mk_frame(29'h1FFF_FFFF, 4'd15, '1));
		drain();

		// Top bit, Intel order: everything past the last byte reads as zero.
		c = '{29'h1FFF_FFFF, 4'd0, 6'd63, 7'd64, 1'b0, 1'b0, 32'h8000_0000, 48'h7FFF_FFFF_FFFF};
		apply_config(c);
		send_frame(mk_frame(29'h1FFF_FFFF, 4'd0, '1));
		send_frame(mk_frame(29'h1FFF_FFFF, 4'd0, 64'h8000_0000_0000_0000));
		send_frame(mk_frame(29'h1FFF_FFFF, 4'd0, '0));
		send_frame(mk_frame(29'd0, 4'd0, '1));
		drain();

		// Over-long length with a large factor drives the output into saturation.
		c = '{29'd0, 4'd8, 6'd0, 7'd127, 1'b0, 1'b0, 32'h7FFF_FFFF, 48'd0};
		apply_config(c);
		send_frame(mk_frame(29'd0, 4'd8, '1));
		send_frame(mk_frame(29'd0, 4'd8, 64'h7FFF_FFFF_FFFF_FFFF));
		send_frame(mk_frame(29'd0, 4'd8, 64'h8000_0000_0000_0000));
		drain();

		// Zero length acts as one bit; a negative factor puts the minimum above the maximum.
		c = '{29'd0, 4'd8, 6'd5, 7'd0, 1'b0, 1'b1, 32'hFFFF_0000, 48'd0};
		apply_config(c);
		send_frame(mk_frame(29'd0, 4'd8, '1));
		send_frame(mk_frame(29'd0, 4'd8, '0));
		drain();

		// Motorola order stepping below the first byte.
		c = '{29'd0, 4'd8, 6'd7, 7'd64, 1'b1, 1'b0, 32'h8000_0000, 48'h8000_0000_0000};
		apply_config(c);
		send_frame(mk_frame(29'd0, 4'd8, '1));
		send_frame(mk_frame(29'd0, 4'd8, {$urandom, $urandom}));
		drain();

		c = '{29'd0, 4'd8, 6'd60, 7'd20, 1'b1, 1'b1, 32'h0003_0000, 48'd12345};
		apply_config(c);
		repeat (3)
			send_frame(mk_frame(29'd0, 4'd8, {$urandom, $urandom}));
		drain();
	endtask

	initial begin
		sig_cfg_t c;

		sb = new;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n <= 1'b0;
		frame_valid <= 1'b0;
		frame <= '0;
		result_ready <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_part();

		for (int phase = 0; phase < 12; phase++) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 61;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 61;
				end
				default: begin
					send_idle_pct = 25;
					recv_stall_pct = 25;
				end
			endcase
			if (phase == 0)
				c = '{29'h1FFF_FFFF, 4'd8, 6'd63, 7'd64, 1'b1, 1'b0, 32'h7FFF_FFFF,
					48'h7FFF_FFFF_FFFF};
			else if (phase == 1)
				c = '{29'd0, 4'd0, 6'd0, 7'd1, 1'b0, 1'b1, 32'h8000_0000, 48'h8000_0000_0000};
			else
				c = random_config();
			apply_config(c);
			repeat (38)
				send_frame(random_frame());
			drain();
		end

		repeat (20)
			@(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
design/can_sx_pkg.sv
design/can_signal_extract_scale.sv
dv/can_signal_extract_scale_tb.sv
